@@ design/ikc_pkg.sv @@
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared constants and types for the interleaved k-mer comparator.
// ----------------------------------------------------------------------------
package ikc_pkg;

  localparam int NUCL_LIMIT = 32;
  localparam int NUCL_W     = 2;
  localparam int SEQ_W      = NUCL_LIMIT * NUCL_W;
  localparam int IDX_W      = $clog2(NUCL_LIMIT);
  localparam int CNT_W      = 6;
  localparam int ORDER_W    = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(21);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(NUCL_LIMIT);

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ORDER_W-1:0] order_t;

  // Order codes, two's complement.
  localparam order_t ORD_EQ = 2'b00;
  localparam order_t ORD_GT = 2'b01;
  localparam order_t ORD_LT = 2'b11;

endpackage

@@ design/ikc_cmp.sv @@
// ----------------------------------------------------------------------------
// ikc_cmp
// Single-pass comparison logic: nearest differing nucleotide around the split.
// ----------------------------------------------------------------------------
module ikc_cmp (
  input  ikc_pkg::seq_t   seq_a_i,
  input  ikc_pkg::seq_t   seq_b_i,
  input  ikc_pkg::cnt_t   split_pos_i,
  input  ikc_pkg::cnt_t   nucl_cnt_i,
  output ikc_pkg::order_t order_o
);
  import ikc_pkg::*;

  cnt_t                  n_eff;
  cnt_t                  p_eff;
  cnt_t                  s_pt;
  logic [NUCL_LIMIT-1:0] diff;
  logic [NUCL_LIMIT-1:0] less;
  logic [NUCL_LIMIT-1:0] up_vec;
  logic [NUCL_LIMIT-1:0] lo_vec;
  logic [IDX_W-1:0]      up_idx;
  logic [IDX_W-1:0]      lo_idx;
  logic [IDX_W-1:0]      pos;
  logic                  up_hit;
  logic                  lo_hit;
  cnt_t                  up_dist;
  cnt_t                  lo_dist;
  logic                  take_up;

  // Pair index i counts from the LSB; the split sits between s_pt-1 and s_pt.
  assign n_eff = (nucl_cnt_i > CNT_MAX) ? CNT_MAX : nucl_cnt_i;
  assign p_eff = (split_pos_i > n_eff) ? n_eff : split_pos_i;
  assign s_pt  = n_eff - p_eff;

  always_comb begin
    for (int i = 0; i < NUCL_LIMIT; i++) begin
      diff[i]   = (seq_a_i[NUCL_W*i +: NUCL_W] != seq_b_i[NUCL_W*i +: NUCL_W]) &&
                  (CNT_W'(i) < n_eff);
      less[i]   = seq_a_i[NUCL_W*i +: NUCL_W] < seq_b_i[NUCL_W*i +: NUCL_W];
      up_vec[i] = diff[i] && (CNT_W'(i) >= s_pt);
      lo_vec[i] = diff[i] && (CNT_W'(i) < s_pt);
    end
  end

  // Lowest set bit of the prefix side, highest of the suffix side.
  always_comb begin
    up_idx = '0;
    lo_idx = '0;
    for (int i = NUCL_LIMIT - 1; i >= 0; i--) begin
      if (up_vec[i]) begin
        up_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < NUCL_LIMIT; i++) begin
      if (lo_vec[i]) begin
        lo_idx = IDX_W'(i);
      end
    end
  end

  assign up_hit  = |up_vec;
  assign lo_hit  = |lo_vec;
  assign up_dist = {1'b0, up_idx} - s_pt;
  assign lo_dist = s_pt - CNT_W'(1) - {1'b0, lo_idx};
  // Tie goes to the suffix side.
  assign take_up = up_hit && (!lo_hit || (up_dist < lo_dist));
  assign pos     = take_up ? up_idx : lo_idx;

  always_comb begin
    if (!up_hit && !lo_hit) begin
      order_o = ORD_EQ;
    end else if (less[pos]) begin
      order_o = ORD_LT;
    end else begin
      order_o = ORD_GT;
    end
  end

endmodule

@@ design/interleaved_kmer_compare.sv @@
// ----------------------------------------------------------------------------
// interleaved_kmer_compare
// The input registers hold the accepted item; the result register holds the order.
// Throughput one item per cycle while the result side does not stall; the comparison is one pass of logic.
// Reset clears both stage valids and loads nucleotide_count with 21.
// A result-side stall holds the input off once both stages are full.
// ----------------------------------------------------------------------------
module interleaved_kmer_compare (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  ikc_pkg::cnt_t cfg_wdata_i,      // nucleotide_count
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,    // seq_a[63:0], seq_b[127:64], split_pos[133:128]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [7:0]   m_axis_tdata_o     // order[1:0]
);
  import ikc_pkg::*;

  cnt_t   cnt_q;
  logic   in_vld_q;
  seq_t   seq_a_q;
  seq_t   seq_b_q;
  cnt_t   split_q;
  logic   out_vld_q;
  order_t order_q;
  order_t order_d;
  logic   out_adv;
  logic   in_adv;

  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign in_adv          = !in_vld_q || out_adv;
  assign s_axis_tready_o = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      seq_a_q <= s_axis_tdata_i[SEQ_W-1:0];
      seq_b_q <= s_axis_tdata_i[2*SEQ_W-1:SEQ_W];
      split_q <= s_axis_tdata_i[2*SEQ_W+CNT_W-1:2*SEQ_W];
    end
    if (out_adv && in_vld_q) begin
      order_q <= order_d;
    end
  end

  ikc_cmp u_cmp (
    .seq_a_i     (seq_a_q),
    .seq_b_i     (seq_b_q),
    .split_pos_i (split_q),
    .nucl_cnt_i  (cnt_q),
    .order_o     (order_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, order_q};

endmodule

@@ tb/ikc_order_checker.sv @@
// ----------------------------------------------------------------------------
// ikc_order_checker
// Watches the register write port and both streams of the comparator. Each
// accepted item is turned into its expected order, which is queued and
// compared with the next result that leaves the block.
// ----------------------------------------------------------------------------
module ikc_order_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  ikc_pkg::cnt_t cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [135:0]  in_data_i,        // seq_a[63:0], seq_b[127:64], split_pos[133:128]
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [7:0]    out_data_i,       // order[1:0]
  output int            fail_count_o,
  output int            pending_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import ikc_pkg::*;

  cnt_t   nucl_count;
  order_t expected_orders[$];
  order_t oldest;

  function automatic order_t kmer_order(seq_t a, seq_t b, logic [5:0] split, cnt_t cnt);
    int n;
    int p;
    int j;
    int pos;
    int pre_idx;
    int suf_idx;
    n = (cnt > CNT_MAX) ? NUCL_LIMIT : int'(cnt);
    p = (int'(split) > n) ? n : int'(split);
    pre_idx = -1;
    suf_idx = -1;
    for (j = p - 1; j >= 0; j--) begin
      if (a[2*(n-1-j) +: 2] != b[2*(n-1-j) +: 2]) begin
        pre_idx = j;
        break;
      end
    end
    for (j = p; j < n; j++) begin
      if (a[2*(n-1-j) +: 2] != b[2*(n-1-j) +: 2]) begin
        suf_idx = j;
        break;
      end
    end
    if (pre_idx < 0 && suf_idx < 0) return ORD_EQ;
    if (pre_idx < 0) pos = suf_idx;
    else if (suf_idx < 0) pos = pre_idx;
    else if (p - pre_idx - 1 < suf_idx - p) pos = pre_idx;
    else pos = suf_idx;  // equal distance: suffix side wins
    return (a[2*(n-1-pos) +: 2] < b[2*(n-1-pos) +: 2]) ? ORD_LT : ORD_GT;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // newest at the front, oldest at the back
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nucl_count = CNT_RESET;
      expected_orders.delete();
      fail_count_o = 0;
      pending_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_orders.push_front(kmer_order(in_data_i[63:0], in_data_i[127:64],
                                              in_data_i[133:128], nucl_count));
      end
      if (cfg_we_i) nucl_count = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_orders.size() == 0) begin
          report_mismatch($sformatf("order %b arrived with nothing pending", out_data_i[1:0]));
        end else begin
          oldest = expected_orders.pop_back();
          if (out_data_i[1:0] !== oldest) begin
            report_mismatch($sformatf("order got %b want %b", out_data_i[1:0], oldest));
          end
        end
      end
      pending_count_o <= expected_orders.size();
    end
  end

endmodule

@@ tb/interleaved_kmer_compare_tb.sv @@
// ----------------------------------------------------------------------------
// interleaved_kmer_compare_tb
// Drives the comparator with hand-picked pairs around the split position,
// then with near-identical random pairs under a range of nucleotide counts,
// with random gaps and stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module interleaved_kmer_compare_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ikc_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  cnt_t         cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i;    // seq_a[63:0], seq_b[127:64], split_pos[133:128]
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [7:0]   m_axis_tdata_o;    // order[1:0]

  int fail_count;
  int pending_count;
  bit quiet;
  bit hold_req;
  int cur_count;

  interleaved_kmer_compare dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  ikc_order_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_i     (s_axis_tready_o),
    .in_data_i      (s_axis_tdata_i),
    .out_valid_i    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_data_i     (m_axis_tdata_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic offer(seq_t a, seq_t b, logic [5:0] split);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, split, b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt_t'(v);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_count = v;
  endtask

  function automatic seq_t put_nucl(seq_t s, int n, int j, logic [1:0] c);
    s[2*(n-1-j) +: 2] = c;
    return s;
  endfunction

  // count is 21 here, so 42 bits are in use
  task automatic directed_items();
    seq_t ones;
    seq_t a;
    seq_t b;
    ones = '1;
    offer('0, '0, 6'd0);
    offer(ones, ones, 6'd10);
    offer('0, ones, 6'd0);
    offer(ones, '0, 6'd21);
    offer('0, ones, 6'd63);
    offer(ones, '0, 6'd32);
    offer('0, ~seq_t'(64'h3FF_FFFF_FFFF), 6'd5);
    offer(ones, seq_t'(64'h3FF_FFFF_FFFF), 6'd21);
    // tie at the split: both sides one step away
    a = put_nucl('0, 21, 9, 2'd3);
    b = put_nucl('0, 21, 10, 2'd1);
    offer(a, b, 6'd10);
    offer(b, a, 6'd10);
    // prefix nearer
    a = put_nucl(put_nucl('0, 21, 9, 2'd2), 21, 11, 2'd0);
    b = put_nucl(put_nucl('0, 21, 9, 2'd1), 21, 11, 2'd3);
    offer(a, b, 6'd10);
    // suffix nearer
    a = put_nucl(put_nucl('0, 21, 7, 2'd2), 21, 11, 2'd0);
    b = put_nucl(put_nucl('0, 21, 7, 2'd1), 21, 11, 2'd3);
    offer(a, b, 6'd10);
    offer(put_nucl('0, 21, 0, 2'd2), put_nucl('0, 21, 0, 2'd1), 6'd21);
    offer(put_nucl('0, 21, 20, 2'd1), put_nucl('0, 21, 20, 2'd2), 6'd0);
    offer(put_nucl('0, 21, 20, 2'd3), put_nucl('0, 21, 20, 2'd0), 6'd21);
    offer(put_nucl('0, 21, 0, 2'd0), put_nucl('0, 21, 0, 2'd3), 6'd1);
    offer(put_nucl(ones, 21, 5, 2'd1), put_nucl(ones, 21, 5, 2'd2), 6'd5);
    offer(put_nucl(ones, 21, 5, 2'd2), put_nucl(ones, 21, 5, 2'd0), 6'd6);
  endtask

  task automatic random_item();
    seq_t a;
    seq_t b;
    seq_t hi_mask;
    logic [5:0] split;
    int nn;
    int flips;
    int q;
    nn = (cur_count > NUCL_LIMIT) ? NUCL_LIMIT : cur_count;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      b = {$urandom, $urandom};
    end else begin
      b = a;
      flips = $urandom_range(0, 3);
      repeat (flips) begin
        q = $urandom_range(0, (nn > 0) ? nn - 1 : 0);
        b[2*q +: 2] = b[2*q +: 2] ^ 2'($urandom_range(1, 3));
      end
    end
    hi_mask = (nn >= NUCL_LIMIT) ? '0 : ~((seq_t'(1) << (2 * nn)) - 1);
    if ($urandom_range(0, 2) == 0) b = b ^ (hi_mask & {$urandom, $urandom});
    if ($urandom_range(0, 7) == 0) split = 6'($urandom_range(0, 63));
    else split = 6'($urandom_range(0, nn));
    offer(a, b, split);
  endtask

  initial begin
    int counts[10];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    cur_count       = int'(CNT_RESET);
    counts = '{63, 0, 1, 2, 32, 33, 21, 0, 16, 0};
    counts[7] = $urandom_range(3, 31);
    counts[9] = $urandom_range(1, 32);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();
    for (int ph = 0; ph < 10; ph++) begin
      set_count(counts[ph]);
      if (ph == 9) quiet = 1'b1;
      for (int i = 0; i < 113; i++) begin
        if (ph == 4 && i == 40) hold_req = 1'b1;
        random_item();
      end
    end
    drain();
    repeat (6) @(posedge clk_i);

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

@@ interleaved_kmer_compare.f @@
design/ikc_pkg.sv
design/ikc_cmp.sv
design/interleaved_kmer_compare.sv
tb/ikc_order_checker.sv
tb/interleaved_kmer_compare_tb.sv
